// ----- rtl/core/csvp_pkg.sv -----
package csvp_pkg;

    // Default depth of the separator lookahead window, in bytes.
    localparam int DEF_MAX_SEP_LEN = 4;

    // The most results that one input byte can produce.
    localparam int RESULT_CAP = 10;
    localparam int RCW        = $clog2(RESULT_CAP + 1);
    localparam int RIW        = $clog2(RESULT_CAP);

    localparam logic [7:0] QUOTE_BYTE = 8'd34;

    // Result kinds, carried on m_tuser.
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_QUOTE_ENABLE   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_COL_SEPARATOR  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_COL_SEP_LENGTH = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_STRICT_COLUMN  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_ROW_SEPARATOR  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_ROW_SEP_LENGTH = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_STRICT_ROW     = 3'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } res_item_t;

    typedef struct packed {
        res_item_t [RESULT_CAP-1:0] item;
        logic [RCW-1:0]             n;
    } rbuf_t;

    // Appends one result unless the list is already full.
    function automatic rbuf_t push(rbuf_t r, logic [1:0] kind, logic [7:0] ch);
        rbuf_t o;
        o = r;
        if (r.n < RCW'(RESULT_CAP)) begin
            o.item[r.n[RIW-1:0]] = {kind, ch};
            o.n = r.n + RCW'(1);
        end
        return o;
    endfunction

endpackage

// ----- rtl/core/csv_stream_parser_core.sv -----
// Latency: the first result of an accepted byte shows on the master side in the next cycle.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready
// is high; a byte that yields several results holds the slave side until only its last
// is left, since the result queue drains one request per cycle while m_tready is high.
// Reset (aresetn low, synchronous): configuration returns to its defaults, the parser
// state and the result queue are cleared; the lookahead bytes themselves are not cleared.
module csv_stream_parser_core
    import csvp_pkg::*;
#(
    parameter int MAX_SEP_LEN = DEF_MAX_SEP_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port.
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_wdata,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // bits 7..0: in_char
    input  logic              s_tlast,   // end_of_input
    // Result stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // bits 7..0: out_char
    output logic [1:0]        m_tuser,   // bits 1..0: kind
    output logic              m_tlast    // final_result
);

    localparam int CW = $clog2(MAX_SEP_LEN + 1);

    // Parser state. The window holds the undecided bytes, oldest in the low byte.
    typedef struct packed {
        logic [MAX_SEP_LEN*8-1:0] win;
        logic [CW-1:0]            cnt;
        logic                     inq;
        logic                     qcp;
        logic                     fhb;
        logic                     swl;
        logic                     rhf;
    } state_t;

    // Configuration registers.
    logic        quote_en_reg;
    logic [31:0] col_sep_reg;
    logic [2:0]  col_len_reg;
    logic        strict_col_reg;
    logic [31:0] row_sep_reg;
    logic [2:0]  row_len_reg;
    logic        strict_row_reg;

    state_t state_reg, state_next;

    // Result queue: entry 0 is the request currently offered on the master side.
    res_item_t [RESULT_CAP-1:0] obuf_reg, obuf_next;
    logic [RCW-1:0]             left_reg, left_next;

    state_t st;
    rbuf_t  rb;

    logic s_fire;
    logic m_fire;

    // A length of zero acts as one; anything above the window depth acts as the depth.
    function automatic logic [CW-1:0] clamp_len(logic [2:0] len);
        logic [CW-1:0] r;
        if (len == 3'd0) begin
            r = CW'(1);
        end else if (int'(len) > MAX_SEP_LEN) begin
            r = CW'(MAX_SEP_LEN);
        end else begin
            r = CW'(len);
        end
        return r;
    endfunction

    // Number of window bytes a separator takes at the window head, zero when it does not
    // match. Loose mode compares the head byte against every valid separator byte; strict
    // mode needs the whole string in order. Separator bytes past the fourth read as zero.
    function automatic logic [CW-1:0] sep_take(
        logic [31:0]              sep,
        logic [CW-1:0]            len,
        logic                     strict_mode,
        logic [MAX_SEP_LEN*8-1:0] win,
        logic [CW-1:0]            cnt
    );
        logic [63:0]   ext;
        logic          any_hit;
        logic          all_hit;
        logic [CW-1:0] r;
        ext     = {32'b0, sep};
        any_hit = 1'b0;
        all_hit = (cnt >= len);
        for (int i = 0; i < MAX_SEP_LEN; i++) begin
            if (CW'(i) < len) begin
                if (ext[8*i +: 8] == win[7:0]) begin
                    any_hit = 1'b1;
                end
                if (ext[8*i +: 8] != win[8*i +: 8]) begin
                    all_hit = 1'b0;
                end
            end
        end
        if (strict_mode) begin
            r = all_hit ? len : '0;
        end else begin
            r = any_hit ? CW'(1) : '0;
        end
        return r;
    endfunction

    // The queue takes a new byte's results once it is empty or its last entry leaves now.
    assign s_tready = (left_reg == '0) || ((left_reg == RCW'(1)) && m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign m_tvalid = (left_reg != '0);
    assign m_tdata  = obuf_reg[0].ch;
    assign m_tuser  = obuf_reg[0].kind;
    assign m_tlast  = (left_reg == RCW'(1));

    // Single pass over one byte: append it to the window, then decide as many window bytes
    // as possible. Each decision takes at least one byte, so the window depth bounds the
    // number of decision steps. A byte outside quotes waits until the window also holds
    // the lookahead that a strict separator needs, unless this is the last byte.
    always_comb begin
        logic [CW-1:0] col_len;
        logic [CW-1:0] row_len;
        logic [CW-1:0] need;
        logic [CW-1:0] k;
        logic [CW-1:0] col_k;
        logic [CW-1:0] row_k;
        logic [7:0]    b;
        logic          stop;
        logic          took;

        st      = state_reg;
        rb      = '0;
        stop    = 1'b0;
        col_len = clamp_len(col_len_reg);
        row_len = clamp_len(row_len_reg);
        need    = '0;
        if (strict_col_reg) begin
            need = col_len - CW'(1);
        end
        if (strict_row_reg && ((row_len - CW'(1)) > need)) begin
            need = row_len - CW'(1);
        end

        if (st.cnt < CW'(MAX_SEP_LEN)) begin
            for (int i = 0; i < MAX_SEP_LEN; i++) begin
                if (st.cnt == CW'(i)) begin
                    st.win[8*i +: 8] = s_tdata;
                end
            end
            st.cnt = st.cnt + CW'(1);
        end

        for (int step = 0; step < MAX_SEP_LEN; step++) begin
            b     = st.win[7:0];
            k     = '0;
            took  = 1'b0;
            col_k = '0;
            row_k = '0;
            if (!stop && (st.cnt != '0)) begin
                // A quote inside quotes is settled by the byte after it: another quote
                // gives one data quote, anything else closes the section.
                if (st.qcp) begin
                    st.qcp = 1'b0;
                    if (b == QUOTE_BYTE) begin
                        st.swl = 1'b0;
                        rb     = push(rb, KIND_DATA, QUOTE_BYTE);
                        st.fhb = 1'b1;
                        k      = CW'(1);
                        took   = 1'b1;
                    end else begin
                        st.inq = 1'b0;
                    end
                end
                if (!took) begin
                    if (quote_en_reg && !st.inq && (b == QUOTE_BYTE)) begin
                        st.swl = 1'b0;
                        st.inq = 1'b1;
                        k      = CW'(1);
                    end else if (st.inq && (b == QUOTE_BYTE)) begin
                        st.swl = 1'b0;
                        st.qcp = 1'b1;
                        k      = CW'(1);
                    end else if (st.inq) begin
                        st.swl = 1'b0;
                        rb     = push(rb, KIND_DATA, b);
                        st.fhb = 1'b1;
                        k      = CW'(1);
                    end else if ((st.cnt <= need) && !s_tlast) begin
                        stop = 1'b1;
                    end else begin
                        st.swl = 1'b0;
                        col_k  = sep_take(col_sep_reg, col_len, strict_col_reg,
                                          st.win, st.cnt);
                        row_k  = sep_take(row_sep_reg, row_len, strict_row_reg,
                                          st.win, st.cnt);
                        // Column separators win over row separators.
                        if (col_k != '0) begin
                            rb     = push(rb, KIND_FIELD_END, 8'd0);
                            st.rhf = 1'b1;
                            st.fhb = 1'b0;
                            st.swl = 1'b1;
                            k      = col_k;
                        end else if (row_k != '0) begin
                            rb     = push(rb, KIND_FIELD_END, 8'd0);
                            rb     = push(rb, KIND_ROW_END, 8'd0);
                            st.rhf = 1'b0;
                            st.fhb = 1'b0;
                            k      = row_k;
                        end else begin
                            rb     = push(rb, KIND_DATA, b);
                            st.fhb = 1'b1;
                            k      = CW'(1);
                        end
                    end
                end
                st.win = st.win >> {k, 3'b000};
                st.cnt = st.cnt - k;
            end
        end

        // At the end of the stream a pending closing quote closes the section, then the
        // open field and the open row are ended, and the parser starts over.
        if (s_tlast) begin
            if (st.qcp) begin
                if (!st.fhb) begin
                    rb     = push(rb, KIND_FIELD_END, 8'd0);
                    st.rhf = 1'b1;
                end
                st.qcp = 1'b0;
                st.inq = 1'b0;
            end
            if (st.fhb || st.swl) begin
                rb     = push(rb, KIND_FIELD_END, 8'd0);
                st.rhf = 1'b1;
            end
            if (st.rhf) begin
                rb = push(rb, KIND_ROW_END, 8'd0);
            end
            st.cnt = '0;
            st.inq = 1'b0;
            st.qcp = 1'b0;
            st.fhb = 1'b0;
            st.swl = 1'b0;
            st.rhf = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        obuf_next  = obuf_reg;
        left_next  = left_reg;
        if (s_fire) begin
            state_next = st;
            obuf_next  = rb.item;
            left_next  = rb.n;
        end else if (m_fire) begin
            obuf_next  = obuf_reg >> $bits(res_item_t);
            left_next  = left_reg - RCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_en_reg   <= 1'b1;
            col_sep_reg    <= 32'd44;
            col_len_reg    <= 3'd1;
            strict_col_reg <= 1'b0;
            row_sep_reg    <= 32'd10;
            row_len_reg    <= 3'd1;
            strict_row_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_QUOTE_ENABLE:   quote_en_reg   <= cfg_wdata[0];
                CFG_COL_SEPARATOR:  col_sep_reg    <= cfg_wdata;
                CFG_COL_SEP_LENGTH: col_len_reg    <= cfg_wdata[2:0];
                CFG_STRICT_COLUMN:  strict_col_reg <= cfg_wdata[0];
                CFG_ROW_SEPARATOR:  row_sep_reg    <= cfg_wdata;
                CFG_ROW_SEP_LENGTH: row_len_reg    <= cfg_wdata[2:0];
                CFG_STRICT_ROW:     strict_row_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Window bytes and queued results carry no reset.
    always_ff @(posedge aclk) begin
        state_reg.win <= state_next.win;
        obuf_reg      <= obuf_next;
        if (!aresetn) begin
            state_reg.cnt <= '0;
            state_reg.inq <= 1'b0;
            state_reg.qcp <= 1'b0;
            state_reg.fhb <= 1'b0;
            state_reg.swl <= 1'b0;
            state_reg.rhf <= 1'b0;
            left_reg      <= '0;
        end else begin
            state_reg.cnt <= state_next.cnt;
            state_reg.inq <= state_next.inq;
            state_reg.qcp <= state_next.qcp;
            state_reg.fhb <= state_next.fhb;
            state_reg.swl <= state_next.swl;
            state_reg.rhf <= state_next.rhf;
            left_reg      <= left_next;
        end
    end

endmodule

// ----- rtl/core/csvp_checker.sv -----
module csvp_checker
    import csvp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // No new byte is taken while results of the previous one remain beyond the current.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready while results are still queued");

    // With nothing queued, the parser always takes a byte.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready with empty result queue");

    // Field and row ends carry a zero byte.
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_DATA) |-> m_tdata == 8'd0)
        else $error("field or row end with nonzero byte");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind csv_stream_parser_core csvp_checker u_csvp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/csv_token_checker.sv -----
module csv_token_checker
    import csvp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    input  logic [1:0]        m_tuser,
    input  logic              m_tlast,
    output int                mismatches,
    output int                pending_cnt,
    output int                checked_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH = DEF_MAX_SEP_LEN;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } csv_token_t;

    csv_token_t  expected_q[$];
    csv_token_t  emitted[$];

    // Shadow of the configuration registers.
    logic        quote_en;
    logic [31:0] col_sep;
    logic [2:0]  col_len;
    logic        col_strict;
    logic [31:0] row_sep;
    logic [2:0]  row_len;
    logic        row_strict;

    // Shadow of the parser state.
    logic [7:0]  look_buf [WIN_DEPTH];
    int unsigned look_cnt;
    logic        in_quotes;
    logic        close_pending;
    logic        field_open;
    logic        sep_last;
    logic        row_open;

    int          errs;
    int          seen;

    function automatic int unsigned sep_len(logic [2:0] len_reg);
        if (len_reg == 3'd0) return 1;
        if (len_reg > 3'(WIN_DEPTH)) return WIN_DEPTH;
        return int'(len_reg);
    endfunction

    // Number of window bytes taken by a separator at the window head, zero when none.
    function automatic int unsigned sep_take(logic [31:0] sep, logic [2:0] len_reg,
                                             logic strict);
        int unsigned n;
        n = sep_len(len_reg);
        if (!strict) begin
            for (int i = 0; i < n; i++)
                if (sep[8*i +: 8] == look_buf[0]) return 1;
            return 0;
        end
        if (look_cnt < n) return 0;
        for (int i = 0; i < n; i++)
            if (sep[8*i +: 8] != look_buf[i]) return 0;
        return n;
    endfunction

    task automatic add_token(logic [1:0] kind, logic [7:0] ch);
        csv_token_t t;
        t.kind = kind;
        t.ch   = (kind == KIND_DATA) ? ch : 8'd0;
        t.last = 1'b0;
        if (emitted.size() < RESULT_CAP) emitted.push_back(t);
    endtask

    task automatic shift_out(int unsigned k);
        if (k > look_cnt) k = look_cnt;
        for (int i = 0; i < look_cnt - k; i++) look_buf[i] = look_buf[i + k];
        look_cnt -= k;
    endtask

    task automatic clear_parse();
        look_cnt      = 0;
        in_quotes     = 1'b0;
        close_pending = 1'b0;
        field_open    = 1'b0;
        sep_last      = 1'b0;
        row_open      = 1'b0;
    endtask

    // Works out every result that one accepted byte causes and queues them in order.
    task automatic absorb_byte(logic [7:0] in_ch, logic eoi);
        int unsigned need;
        int unsigned k;
        logic [7:0]  b;
        emitted.delete();
        need = 0;
        if (col_strict) need = sep_len(col_len) - 1;
        if (row_strict && sep_len(row_len) - 1 > need) need = sep_len(row_len) - 1;
        if (look_cnt < WIN_DEPTH) begin
            look_buf[look_cnt] = in_ch;
            look_cnt++;
        end
        while (look_cnt > 0) begin
            b = look_buf[0];
            if (close_pending) begin
                close_pending = 1'b0;
                if (b == QUOTE_BYTE) begin
                    sep_last = 1'b0;
                    add_token(KIND_DATA, QUOTE_BYTE);
                    field_open = 1'b1;
                    shift_out(1);
                    continue;
                end
                in_quotes = 1'b0;
            end
            if (quote_en && !in_quotes && b == QUOTE_BYTE) begin
                sep_last  = 1'b0;
                in_quotes = 1'b1;
                shift_out(1);
            end else if (in_quotes && b == QUOTE_BYTE) begin
                sep_last      = 1'b0;
                close_pending = 1'b1;
                shift_out(1);
            end else if (in_quotes) begin
                sep_last = 1'b0;
                add_token(KIND_DATA, b);
                field_open = 1'b1;
                shift_out(1);
            end else begin
                // Outside quotes a byte waits for the lookahead that strict matching needs.
                if (look_cnt < need + 1 && !eoi) break;
                sep_last = 1'b0;
                k = sep_take(col_sep, col_len, col_strict);
                if (k != 0) begin
                    add_token(KIND_FIELD_END, 8'd0);
                    row_open   = 1'b1;
                    field_open = 1'b0;
                    sep_last   = 1'b1;
                    shift_out(k);
                end else begin
                    k = sep_take(row_sep, row_len, row_strict);
                    if (k != 0) begin
                        add_token(KIND_FIELD_END, 8'd0);
                        add_token(KIND_ROW_END, 8'd0);
                        row_open   = 1'b0;
                        field_open = 1'b0;
                        shift_out(k);
                    end else begin
                        add_token(KIND_DATA, b);
                        field_open = 1'b1;
                        shift_out(1);
                    end
                end
            end
        end
        if (eoi) begin
            if (close_pending) begin
                if (!field_open) begin
                    add_token(KIND_FIELD_END, 8'd0);
                    row_open = 1'b1;
                end
                close_pending = 1'b0;
                in_quotes     = 1'b0;
            end
            if (field_open || sep_last) begin
                add_token(KIND_FIELD_END, 8'd0);
                row_open = 1'b1;
            end
            if (row_open) add_token(KIND_ROW_END, 8'd0);
            clear_parse();
        end
        if (emitted.size() > 0) emitted[emitted.size() - 1].last = 1'b1;
        foreach (emitted[i]) expected_q.push_back(emitted[i]);
    endtask

    always @(posedge aclk) begin
        csv_token_t want;
        if (!aresetn) begin
            quote_en   = 1'b1;
            col_sep    = 32'd44;
            col_len    = 3'd1;
            col_strict = 1'b0;
            row_sep    = 32'd10;
            row_len    = 3'd1;
            row_strict = 1'b0;
            clear_parse();
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_QUOTE_ENABLE:   quote_en   = cfg_wdata[0];
                    CFG_COL_SEPARATOR:  col_sep    = cfg_wdata;
                    CFG_COL_SEP_LENGTH: col_len    = cfg_wdata[2:0];
                    CFG_STRICT_COLUMN:  col_strict = cfg_wdata[0];
                    CFG_ROW_SEPARATOR:  row_sep    = cfg_wdata;
                    CFG_ROW_SEP_LENGTH: row_len    = cfg_wdata[2:0];
                    CFG_STRICT_ROW:     row_strict = cfg_wdata[0];
                    default: ;
                endcase
            end
            // Results are compared before the new byte is predicted; its results go to the back.
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%t: unexpected result kind=%0d char=%02h last=%0b",
                                 $realtime, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = expected_q.pop_front();
                    seen++;
                    if (m_tuser !== want.kind || m_tdata !== want.ch ||
                        m_tlast !== want.last) begin
                        errs++;
                        if (errs <= 10)
                            $display({"%t: result mismatch: expected kind=%0d char=%02h ",
                                      "last=%0b, got kind=%0d char=%02h last=%0b"},
                                     $realtime, want.kind, want.ch, want.last,
                                     m_tuser, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
        end
        mismatches  <= errs;
        pending_cnt <= expected_q.size();
        checked_cnt <= seen;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csvp_pkg::*;

    // The generous cycle ceiling. The slowest correct run has a few hundred bytes, each
    // waiting out a long sender gap and up to ten results behind long receiver stalls,
    // which still stays well below the limit.
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_BYTES = 135;
    localparam int PHASE_BYTES  = 35;
    // Cycles to let pass after the last expected result before touching the registers:
    // a byte that causes no result still changes the parser state inside the block.
    localparam int SETTLE       = 8;
    // The register list has seven entries; a write to the last index must be ignored.
    localparam logic [CFG_IW-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef struct packed {
        logic        quote_en;
        logic [31:0] col_sep;
        logic [2:0]  col_len;
        logic        col_strict;
        logic [31:0] row_sep;
        logic [2:0]  row_len;
        logic        row_strict;
    } csv_setting_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [31:0]       cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    int mismatches;
    int pending_cnt;
    int checked_cnt;

    int           cycles       = 0;
    int           bytes_sent   = 0;
    int           streams_sent = 0;
    int           settings_run = 0;
    int unsigned  stall_left   = 0;
    bit           calm         = 1'b0;
    csv_setting_t cur;
    logic [7:0]   text[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    csv_stream_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The checker watches both streams and the register port beside the block.
    csv_token_checker u_token_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending_cnt(pending_cnt),
        .checked_cnt(checked_cnt)
    );

    // Idle stretches are mostly short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 90) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic int unsigned live_len(logic [2:0] len_reg);
        if (len_reg == 3'd0) return 1;
        if (len_reg > 3'd4) return 4;
        return int'(len_reg);
    endfunction

    // The receiver stalls at random, except during calm phases where it always accepts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = idle_len();
        end
    end

    // The cycle counter ends a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results still expected.",
                     pending_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Presents one byte and holds it until the block takes the request. Valid stays high
    // between back-to-back bytes, so it gets at most one assignment per time step.
    task automatic send_byte(logic [7:0] ch, logic eoi);
        int unsigned gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 30) gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Sends the text buffer; when close is set the last byte ends the stream.
    task automatic send_text(bit close);
        foreach (text[i]) send_byte(text[i], close && i == text.size() - 1);
        if (close) streams_sent++;
        text.delete();
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    // The sender pauses until every expected result has come out, then lets the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_cnt != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_setting(csv_setting_t s);
        write_reg(CFG_QUOTE_ENABLE,   {31'd0, s.quote_en});
        write_reg(CFG_COL_SEPARATOR,  s.col_sep);
        write_reg(CFG_COL_SEP_LENGTH, {29'd0, s.col_len});
        write_reg(CFG_STRICT_COLUMN,  {31'd0, s.col_strict});
        write_reg(CFG_ROW_SEPARATOR,  s.row_sep);
        write_reg(CFG_ROW_SEP_LENGTH, {29'd0, s.row_len});
        write_reg(CFG_STRICT_ROW,     {31'd0, s.row_strict});
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur = s;
        settings_run++;
    endtask

    function automatic logic [2:0] pick_len();
        if ($urandom_range(0, 9) < 8) return 3'($urandom_range(1, 2));
        return 3'($urandom_range(0, 7));
    endfunction

    // Separator bytes lean toward the usual delimiters so that rows and fields really form.
    task automatic random_setting();
        csv_setting_t s;
        s.quote_en = 1'($urandom_range(0, 3) != 0);
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0: s.col_sep[8*i +: 8] = 8'h2C;
                1: s.col_sep[8*i +: 8] = 8'h3B;
                2: s.col_sep[8*i +: 8] = 8'h09;
                3: s.col_sep[8*i +: 8] = 8'h7C;
                4: s.col_sep[8*i +: 8] = 8'h3A;
                default: s.col_sep[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0: s.row_sep[8*i +: 8] = 8'h0A;
                1: s.row_sep[8*i +: 8] = 8'h0D;
                2: s.row_sep[8*i +: 8] = 8'h3B;
                default: s.row_sep[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        s.col_len    = pick_len();
        s.row_len    = pick_len();
        s.col_strict = 1'($urandom_range(0, 1));
        s.row_strict = 1'($urandom_range(0, 1));
        load_setting(s);
    endtask

    // A strict separator goes in whole; a loose one needs just one of its bytes.
    task automatic add_sep(logic [31:0] sep, logic [2:0] len_reg, logic strict);
        int unsigned n;
        n = live_len(len_reg);
        if (strict) begin
            for (int i = 0; i < n; i++) text.push_back(sep[8*i +: 8]);
        end else begin
            text.push_back(sep[8*$urandom_range(0, n - 1) +: 8]);
        end
    endtask

    function automatic logic [7:0] text_char();
        string plain;
        plain = "abxyz019 ";
        if ($urandom_range(0, 9) < 7) return plain[$urandom_range(0, plain.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // A well-formed stream: rows of fields with random content, some fields quoted with
    // doubled quotes inside, and sometimes no row separator before the end of input.
    task automatic build_table();
        int unsigned rows;
        int unsigned cols;
        int unsigned len;
        bit          quoted;
        rows = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
            cols = $urandom_range(1, 3);
            for (int c = 0; c < cols; c++) begin
                if (c > 0) add_sep(cur.col_sep, cur.col_len, cur.col_strict);
                quoted = cur.quote_en && $urandom_range(0, 99) < 35;
                len = $urandom_range(0, 4);
                if (quoted) text.push_back(QUOTE_BYTE);
                for (int i = 0; i < len; i++) begin
                    if (quoted && $urandom_range(0, 4) == 0) begin
                        text.push_back(QUOTE_BYTE);
                        text.push_back(QUOTE_BYTE);
                    end else begin
                        text.push_back(text_char());
                    end
                end
                if (quoted) text.push_back(QUOTE_BYTE);
            end
            if (r < rows - 1 || $urandom_range(0, 1) == 1)
                add_sep(cur.row_sep, cur.row_len, cur.row_strict);
        end
    endtask

    // Noise: stray quotes, separator fragments and arbitrary bytes.
    task automatic build_noise();
        int unsigned n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: text.push_back(QUOTE_BYTE);
                1: text.push_back(cur.col_sep[8*$urandom_range(0, 3) +: 8]);
                2: text.push_back(cur.row_sep[8*$urandom_range(0, 3) +: 8]);
                default: text.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        csv_setting_t s;
        int           phase_bytes;
        int           random_sent;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: a doubled quote, a closing quote decided by a row separator,
        // and an input that ends right after a column separator.
        add_str("\"a\"\"\"\n,");
        send_text(1'b1);
        // A closing quote still pending at the end of input ends an empty field.
        add_str("\"\"");
        send_text(1'b1);
        // A quote left open at the end of input is closed as a normal field.
        text.push_back(QUOTE_BYTE);
        text.push_back(8'h00);
        send_text(1'b1);

        // Strict two-byte separators: a partial match, full matches, and a match that
        // would need bytes beyond the end of input. The unused index must change nothing.
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        s = '{quote_en: 1'b0, col_sep: 32'h0000_3A3A, col_len: 3'd2, col_strict: 1'b1,
              row_sep: 32'h0000_0A0D, row_len: 3'd2, row_strict: 1'b1};
        load_setting(s);
        add_str(":z::\r\n\r");
        send_text(1'b1);

        // Length extremes: a zero column length acts as one byte, a row length of seven
        // acts as four, and the row separator is all ones.
        wait_idle();
        s = '{quote_en: 1'b1, col_sep: 32'hFFFF_FF3B, col_len: 3'd0, col_strict: 1'b0,
              row_sep: 32'hFFFF_FFFF, row_len: 3'd7, row_strict: 1'b1};
        load_setting(s);
        text.push_back(8'h3B);
        repeat (5) text.push_back(8'hFF);
        send_text(1'b1);

        // Quoting turned off while a quoted section is open: quotes still double and close.
        add_str("\"a");
        send_text(1'b0);
        wait_idle();
        write_reg(CFG_QUOTE_ENABLE, 32'd0);
        cfg_we <= 1'b0;
        @(posedge aclk);
        cur.quote_en = 1'b0;
        add_str("\"\"d\"e");
        send_text(1'b1);

        // Random phases, each under a fresh setting; some phases run with no idling at all.
        random_sent = 0;
        phase_bytes = PHASE_BYTES;
        while (random_sent < RANDOM_BYTES) begin
            if (phase_bytes >= PHASE_BYTES) begin
                wait_idle();
                random_setting();
                calm = ($urandom_range(0, 3) == 0);
                phase_bytes = 0;
            end
            if ($urandom_range(0, 99) < 75) build_table();
            else build_noise();
            phase_bytes += text.size();
            random_sent += text.size();
            send_text(1'b1);
        end

        wait_idle();
        $display("Sent %0d bytes in %0d streams under %0d register settings.",
                 bytes_sent, streams_sent, settings_run);
        $display("Checked %0d results over quoting, strict and loose separators,",
                 checked_cnt);
        $display("clamped lengths and end-of-input closing.");
        if (mismatches == 0 && pending_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", mismatches, pending_cnt);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/csvp_pkg.sv
rtl/core/csv_stream_parser_core.sv
rtl/core/csvp_checker.sv
tb/csv_token_checker.sv
tb/tb_top.sv
